// ----- hdl/kcl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package kcl_pkg;

   // Fixed field widths of the channels
   localparam int KEY_W          = 5;
   localparam int ENTRY_VALUE_W  = 14;
   localparam int ENTRY_DIGITS_W = 3;
   localparam int FAIL_W         = 3;
   localparam int CHANGE_W       = 2;
   localparam int END_W          = 2;

   localparam int CODE_DIGITS_DEFAULT = 4;
   localparam int DEFAULT_CODE        = 1234;

   localparam logic [FAIL_W-1:0]   FAIL_MAX         = 3'd7;
   localparam logic [FAIL_W-1:0]   FAIL_LIMIT_RESET = 3'd3;

   // change key press count: one press opens change mode, a second leaves
   localparam logic [CHANGE_W-1:0] CHANGE_MAX    = 2'd3;
   localparam logic [CHANGE_W-1:0] CHANGE_ACTIVE = 2'd1;
   localparam logic [CHANGE_W-1:0] CHANGE_LEAVE  = 2'd2;

   localparam logic [KEY_W-1:0] KEY_DIGIT_FIRST = 5'd1;

   typedef enum logic [KEY_W-1:0] {
      KEY_NONE    = 5'd0,
      KEY_ZERO    = 5'd10,   // last digit key, stands for 0
      KEY_CONFIRM = 5'd13,
      KEY_DELETE  = 5'd14,
      KEY_CHANGE  = 5'd15,
      KEY_SAVE    = 5'd16
   } key_type;

   typedef enum logic [END_W-1:0] {
      END_NONE  = 2'd0,
      END_SAVED = 2'd1,
      END_LEFT  = 2'd2
   } end_type;

   // session control -> entry datapath
   typedef struct packed {
      logic digit_en;
      logic entry_clear;
      logic count_clear;
      logic hist_clear;
   } entry_cmd_type;

   // per-request status flags, taken after the step
   typedef struct packed {
      logic    unlocked;
      logic    change_mode;
      logic    wrong_code;
      logic    alarm;
      end_type session_end;
   } status_type;

   // binary width of a code of the given digit count; always wide enough
   // to hold the default code
   function automatic int code_width(input int digits);
      int w;
      w = $clog2(10 ** digits);
      if (w < $clog2(DEFAULT_CODE + 1)) w = $clog2(DEFAULT_CODE + 1);
      return w;
   endfunction

   function automatic int count_width(input int digits);
      return $clog2(digits + 1);
   endfunction

   function automatic int index_width(input int digits);
      return ($clog2(digits) < 1) ? 1 : $clog2(digits);
   endfunction

   function automatic logic [3:0] key_digit(input logic [KEY_W-1:0] key);
      logic [3:0] d;
      d = (key == KEY_ZERO) ? 4'd0 : key[3:0];
      return d;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/kcl_req_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface kcl_req_if;
   import kcl_pkg::*;

   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] key_code;

   modport source (output valid, output key_code, input ready);
   modport sink   (input valid, input key_code, output ready);
endinterface

`default_nettype wire

// ----- hdl/kcl_rsp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface kcl_rsp_if;
   import kcl_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [ENTRY_VALUE_W-1:0]  entry_value;
   logic [ENTRY_DIGITS_W-1:0] entry_digits;
   logic                      unlocked;
   logic                      change_mode;
   logic                      wrong_code;
   logic                      alarm;
   logic [END_W-1:0]          session_end;

   modport source (output valid, output entry_value, output entry_digits,
                   output unlocked, output change_mode, output wrong_code,
                   output alarm, output session_end, input ready);
   modport sink   (input valid, input entry_value, input entry_digits,
                   input unlocked, input change_mode, input wrong_code,
                   input alarm, input session_end, output ready);
endinterface

`default_nettype wire

// ----- hdl/kcl_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kcl_in_stage (
   input  wire logic                      clock,
   input  wire logic                      reset,
   kcl_req_if.sink                        req,
   input  wire logic                      advance,
   output logic                           in_valid,
   output logic [kcl_pkg::KEY_W-1:0]      in_key
);
   import kcl_pkg::*;

   logic             in_valid_ff;
   logic [KEY_W-1:0] key_ff;

   // holding slot frees up in the same cycle it moves on
   assign req.ready = !in_valid_ff || advance;
   assign in_valid  = in_valid_ff;
   assign in_key    = key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.valid && req.ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         key_ff <= req.key_code;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/kcl_entry.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kcl_entry #(
   parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEFAULT
) (
   input  wire logic                                              clock,
   input  wire logic                                              reset,
   input  wire logic                                              step,
   input  wire logic [kcl_pkg::KEY_W-1:0]                         key_code,
   input  wire kcl_pkg::entry_cmd_type                            cmd,
   output logic [kcl_pkg::code_width(CODE_DIGITS)-1:0]            entry_code,
   output logic [kcl_pkg::code_width(CODE_DIGITS)-1:0]            entry_code_in,
   output logic [kcl_pkg::count_width(CODE_DIGITS)-1:0]           digit_count_in
);
   import kcl_pkg::*;

   localparam int CODE_W = code_width(CODE_DIGITS);
   localparam int CNT_W  = count_width(CODE_DIGITS);
   localparam int IDX_W  = index_width(CODE_DIGITS);
   localparam logic [CNT_W-1:0] COUNT_FULL = CNT_W'(CODE_DIGITS);

   logic [CODE_W-1:0] entry_code_ff;
   logic [CNT_W-1:0]  digit_count_ff;
   // hist_ff[k] holds the entry as it was with k digits typed; delete
   // steps back to it instead of dividing by ten
   logic [CODE_W-1:0] hist_ff [CODE_DIGITS];

   logic              is_digit;
   logic              push;
   logic              pop;
   logic [CNT_W-1:0]  count_dec;
   logic [IDX_W-1:0]  push_idx;
   logic [IDX_W-1:0]  pop_idx;

   assign entry_code = entry_code_ff;

   always_comb begin
      is_digit  = (key_code >= KEY_DIGIT_FIRST) && (key_code <= KEY_ZERO);
      push      = is_digit && cmd.digit_en && (digit_count_ff < COUNT_FULL);
      pop       = (key_code == KEY_DELETE) && (digit_count_ff != '0);
      count_dec = digit_count_ff - CNT_W'(1);
      push_idx  = digit_count_ff[IDX_W-1:0];
      pop_idx   = count_dec[IDX_W-1:0];

      entry_code_in  = entry_code_ff;
      digit_count_in = digit_count_ff;
      if (push) begin
         // x*10 as two shifts and an add
         entry_code_in  = (entry_code_ff << 3) + (entry_code_ff << 1)
                          + CODE_W'(key_digit(key_code));
         digit_count_in = digit_count_ff + CNT_W'(1);
      end else if (pop) begin
         entry_code_in  = hist_ff[pop_idx];
         digit_count_in = count_dec;
      end
      if (cmd.entry_clear) entry_code_in  = '0;
      if (cmd.count_clear) digit_count_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_code_ff  <= '0;
         digit_count_ff <= '0;
      end else if (step) begin
         entry_code_ff  <= entry_code_in;
         digit_count_ff <= digit_count_in;
      end
   end

   // change key zeroes the entry but keeps the count, so every prefix
   // has to read back as zero afterwards
   always_ff @(posedge clock) begin
      if (step) begin
         if (cmd.hist_clear) begin
            for (int i = 0; i < CODE_DIGITS; i++) hist_ff[i] <= '0;
         end else if (push) begin
            hist_ff[push_idx] <= entry_code_ff;
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      digit_count_ff <= COUNT_FULL)
      else $error("digit count beyond code length");

endmodule

`default_nettype wire

// ----- hdl/kcl_session.sv -----
`timescale 1ns / 1ps
`default_nettype none

module kcl_session #(
   parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEFAULT
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      step,
   input  wire logic [kcl_pkg::KEY_W-1:0]                 key_code,
   input  wire logic [kcl_pkg::code_width(CODE_DIGITS)-1:0] entry_code,
   input  wire logic                                      csr_write_en,
   input  wire logic [kcl_pkg::FAIL_W-1:0]                csr_write_data,
   output kcl_pkg::entry_cmd_type                         cmd,
   output kcl_pkg::status_type                            status_in
);
   import kcl_pkg::*;

   localparam int CODE_W = code_width(CODE_DIGITS);

   logic [CODE_W-1:0]   stored_code_ff, stored_code_in;
   logic [FAIL_W-1:0]   fail_count_ff, fail_count_in;
   logic [FAIL_W-1:0]   fail_limit_ff;
   logic                unlocked_ff, unlocked_in;
   logic                keys_off_ff, keys_off_in;
   logic [CHANGE_W-1:0] change_ff, change_in;

   logic                change_hit;
   logic [CHANGE_W-1:0] change_chg;
   logic                code_match;
   logic                wrong;
   end_type             ended;

   always_comb begin
      change_hit = (key_code == KEY_CHANGE) && unlocked_ff;
      change_chg = (change_hit && (change_ff != CHANGE_MAX))
                   ? change_ff + CHANGE_W'(1) : change_ff;
      code_match = (entry_code == stored_code_ff);

      stored_code_in  = stored_code_ff;
      unlocked_in     = unlocked_ff;
      keys_off_in     = change_hit ? 1'b0 : keys_off_ff;
      change_in       = change_chg;
      fail_count_in   = change_hit ? '0 : fail_count_ff;
      wrong           = 1'b0;
      ended           = END_NONE;
      cmd.digit_en    = !keys_off_ff;
      cmd.entry_clear = change_hit;
      cmd.count_clear = 1'b0;
      cmd.hist_clear  = change_hit;

      if ((key_code == KEY_SAVE) && (change_chg == CHANGE_ACTIVE)) begin
         stored_code_in  = entry_code;
         unlocked_in     = 1'b0;
         keys_off_in     = 1'b0;
         change_in       = '0;
         cmd.entry_clear = 1'b1;
         cmd.count_clear = 1'b1;
         ended           = END_SAVED;
      end else if (!unlocked_ff) begin
         if (key_code == KEY_CONFIRM) begin
            cmd.count_clear = 1'b1;
            if (code_match) begin
               fail_count_in = '0;
               unlocked_in   = 1'b1;
               keys_off_in   = 1'b1;
            end else begin
               if (fail_count_ff != FAIL_MAX) begin
                  fail_count_in = fail_count_ff + FAIL_W'(1);
               end
               cmd.entry_clear = 1'b1;
               wrong           = 1'b1;
            end
         end
      end else if (change_chg >= CHANGE_LEAVE) begin
         // second change press: leave with the old code
         unlocked_in     = 1'b0;
         keys_off_in     = 1'b0;
         change_in       = '0;
         cmd.entry_clear = 1'b1;
         cmd.count_clear = 1'b1;
         ended           = END_LEFT;
      end

      status_in.unlocked    = unlocked_in;
      status_in.change_mode = (change_in == CHANGE_ACTIVE);
      status_in.wrong_code  = wrong;
      status_in.alarm       = (fail_count_in >= fail_limit_ff);
      status_in.session_end = ended;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_code_ff <= CODE_W'(DEFAULT_CODE);
         fail_count_ff  <= '0;
         unlocked_ff    <= 1'b0;
         keys_off_ff    <= 1'b0;
         change_ff      <= '0;
      end else if (step) begin
         stored_code_ff <= stored_code_in;
         fail_count_ff  <= fail_count_in;
         unlocked_ff    <= unlocked_in;
         keys_off_ff    <= keys_off_in;
         change_ff      <= change_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fail_limit_ff <= FAIL_LIMIT_RESET;
      end else if (csr_write_en) begin
         fail_limit_ff <= csr_write_data;
      end
   end

   a_keys_off_unlocked: assert property (@(posedge clock) disable iff (reset)
      keys_off_ff |-> unlocked_ff)
      else $error("digit keys disabled outside an open session");

   a_change_unlocked: assert property (@(posedge clock) disable iff (reset)
      (change_ff != '0) |-> unlocked_ff)
      else $error("change count set while locked");

   a_change_bound: assert property (@(posedge clock) disable iff (reset)
      change_ff < CHANGE_LEAVE)
      else $error("change count left at leave value");

endmodule

`default_nettype wire

// ----- hdl/keypad_code_lock.sv -----
// Keypad code lock. Each request carries one key code (0 none, 1-10 digits
// with 10 meaning 0, 13 confirm, 14 delete, 15 change, 16 save; all other
// codes do nothing) and produces exactly one response with the state after
// that key: the typed entry and its digit count, unlocked and change-mode
// flags, a wrong-code pulse, the alarm flag and the session-end code
// (1 new code saved, 2 left without change). The stored code resets to
// 1234. csr_write_data sets the alarm threshold on the failure count
// (reset 3, failures saturate at 7, a threshold of 0 keeps alarm high);
// write it only while no request is in flight. Throughput is one request
// per clock while the response side does not stall. A request lands in the
// input register when it is accepted; the combinational key step loads the
// response register from it once the response slot is empty or drains.
// The key step itself is one shift-add, one code compare and the flag
// update, so it sets the clock, and a new request is taken every cycle
// the response register can move. Delete steps back through a small
// per-digit history, so there is no divider anywhere.
`timescale 1ns / 1ps
`default_nettype none

module keypad_code_lock #(
   parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   kcl_req_if.sink                           req_ch,
   kcl_rsp_if.source                         rsp_ch,
   input  wire logic                         csr_write_en,
   input  wire logic [kcl_pkg::FAIL_W-1:0]   csr_write_data
);
   import kcl_pkg::*;

   localparam int CODE_W   = code_width(CODE_DIGITS);
   localparam int CNT_W    = count_width(CODE_DIGITS);
   localparam int VALUE_XW = CODE_W + ENTRY_VALUE_W;
   localparam int DIGIT_XW = CNT_W + ENTRY_DIGITS_W;

   // input register
   logic             in_valid;
   logic [KEY_W-1:0] in_key;
   logic             advance;

   // step logic
   entry_cmd_type     cmd;
   status_type        status_in;
   logic [CODE_W-1:0] entry_code;
   logic [CODE_W-1:0] entry_code_in;
   logic [CNT_W-1:0]  digit_count_in;
   logic [VALUE_XW-1:0] entry_wide;
   logic [DIGIT_XW-1:0] count_wide;

   // response register
   logic                      rsp_valid_ff;
   logic [ENTRY_VALUE_W-1:0]  entry_value_ff;
   logic [ENTRY_DIGITS_W-1:0] entry_digits_ff;
   status_type                status_ff;

   // the held request steps whenever the response slot is empty or drains
   assign advance = in_valid && (!rsp_valid_ff || rsp_ch.ready);

   kcl_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .advance  (advance),
      .in_valid (in_valid),
      .in_key   (in_key)
   );

   kcl_session #(
      .CODE_DIGITS (CODE_DIGITS)
   ) u_session (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .key_code       (in_key),
      .entry_code     (entry_code),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .cmd            (cmd),
      .status_in      (status_in)
   );

   kcl_entry #(
      .CODE_DIGITS (CODE_DIGITS)
   ) u_entry (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .key_code       (in_key),
      .cmd            (cmd),
      .entry_code     (entry_code),
      .entry_code_in  (entry_code_in),
      .digit_count_in (digit_count_in)
   );

   // display fields are the low bits of the entry and count
   assign entry_wide = VALUE_XW'(entry_code_in);
   assign count_wide = DIGIT_XW'(digit_count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_value_ff  <= entry_wide[ENTRY_VALUE_W-1:0];
         entry_digits_ff <= count_wide[ENTRY_DIGITS_W-1:0];
         status_ff       <= status_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.entry_value  = entry_value_ff;
   assign rsp_ch.entry_digits = entry_digits_ff;
   assign rsp_ch.unlocked     = status_ff.unlocked;
   assign rsp_ch.change_mode  = status_ff.change_mode;
   assign rsp_ch.wrong_code   = status_ff.wrong_code;
   assign rsp_ch.alarm        = status_ff.alarm;
   assign rsp_ch.session_end  = status_ff.session_end;

   // a closed session shows a clean, locked lock
   a_end_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff.session_end != END_NONE)) |->
      (!status_ff.unlocked && !status_ff.change_mode && (entry_digits_ff == '0)))
      else $error("session end with state left over");

   // a mismatch clears the entry and keeps the lock shut
   a_wrong_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff.wrong_code) |->
      (!status_ff.unlocked && (entry_value_ff == '0) && (entry_digits_ff == '0)))
      else $error("wrong code response with entry or unlock set");

   // a held request that cannot step stays held
   a_hold_request: assert property (@(posedge clock) disable iff (reset)
      (in_valid && !advance) |=> in_valid)
      else $error("held request dropped");

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
   import kcl_pkg::*;

   localparam int DIGITS            = CODE_DIGITS_DEFAULT;
   localparam int STALL_HOLD_CYCLES = 60;     // long receiver hold-off
   localparam int WATCHDOG_LIMIT    = 2000;   // cycles with no request or response moving
   localparam int DRAIN_CYCLES      = 6;      // margin after the lock drains
   localparam int PHASE_PRESSES     = 280;    // meaningful keys per random phase

   // key codes with no function in the lock
   localparam logic [KEY_W-1:0] KEY_UNUSED_A   = 5'd11;
   localparam logic [KEY_W-1:0] KEY_UNUSED_B   = 5'd12;
   localparam logic [KEY_W-1:0] KEY_UNUSED_TOP = 5'd31;

   // one response as the lock shows it after a key
   typedef struct packed {
      logic [ENTRY_VALUE_W-1:0]  value;
      logic [ENTRY_DIGITS_W-1:0] digits;
      logic                      unlocked;
      logic                      change_mode;
      logic                      wrong_code;
      logic                      alarm;
      end_type                   session_end;
   } lock_view_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write_en;
   logic [FAIL_W-1:0] csr_write_data;

   kcl_req_if req_bus ();
   kcl_rsp_if rsp_bus ();

   keypad_code_lock #(.CODE_DIGITS(DIGITS)) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_bus),
      .rsp_ch         (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Lock model: mirrors the key step, updated as each request is taken
   // ---------------------------------------------------------------
   logic [ENTRY_VALUE_W-1:0] saved_code;
   int unsigned              typed_value;
   int unsigned              typed_count;
   logic [FAIL_W-1:0]        miss_count;
   logic [FAIL_W-1:0]        alarm_level;
   logic [CHANGE_W-1:0]      change_count;
   bit                       session_open;
   bit                       digits_locked;

   lock_view_type awaited_status[$];   // one per request taken, oldest first
   int          errors        = 0;
   int unsigned presses_sent  = 0;   // keys that do something, for phase length
   int unsigned idle_cycles   = 0;
   bit          quiet         = 1'b0;  // no gaps on either side
   bit          stall_request = 1'b0;  // ask the receiver for a long hold-off
   bit          stall_active  = 1'b0;

   function automatic void end_session();
      typed_value   = 0;
      typed_count   = 0;
      session_open  = 1'b0;
      digits_locked = 1'b0;
      change_count  = '0;
   endfunction

   function automatic void reset_lock_model();
      alarm_level = FAIL_LIMIT_RESET;
      saved_code  = ENTRY_VALUE_W'(DEFAULT_CODE);
      miss_count  = '0;
      end_session();
   endfunction

   function automatic lock_view_type apply_key(input logic [KEY_W-1:0] key);
      lock_view_type view;
      end_type    ending;
      bit         wrong;
      ending = END_NONE;
      wrong  = 1'b0;
      // digits shift in until the entry is full, unless keys are locked out
      if (key >= KEY_DIGIT_FIRST && key <= KEY_ZERO && !digits_locked
          && typed_count < DIGITS) begin
         typed_value = typed_value * 10 + 32'(key) % 10;
         typed_count++;
      end
      // delete works even with digits locked out
      if (key == KEY_DELETE && typed_count > 0) begin
         typed_value /= 10;
         typed_count--;
      end
      if (key == KEY_CHANGE && session_open) begin
         if (change_count < CHANGE_MAX) change_count++;
         typed_value   = 0;
         miss_count    = '0;
         digits_locked = 1'b0;
      end
      if (key == KEY_SAVE && change_count == CHANGE_ACTIVE) begin
         saved_code = typed_value[ENTRY_VALUE_W-1:0];
         end_session();
         ending = END_SAVED;
      end else if (!session_open) begin
         if (key == KEY_CONFIRM) begin
            if (typed_value == 32'(saved_code)) begin
               typed_count   = 0;
               miss_count    = '0;
               session_open  = 1'b1;
               digits_locked = 1'b1;
            end else begin
               if (miss_count < FAIL_MAX) miss_count++;
               typed_value = 0;
               typed_count = 0;
               wrong       = 1'b1;
            end
         end
      end else if (change_count >= CHANGE_LEAVE) begin
         // second change press: leave without a new code
         end_session();
         ending = END_LEFT;
      end
      view.value       = typed_value[ENTRY_VALUE_W-1:0];
      view.digits      = typed_count[ENTRY_DIGITS_W-1:0];
      view.unlocked    = session_open;
      view.change_mode = (change_count == CHANGE_ACTIVE);
      view.wrong_code  = wrong;
      view.alarm       = (miss_count >= alarm_level);
      view.session_end = ending;
      return view;
   endfunction

   // ---------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(13, 40);
   endfunction

   // Offer one key after a random gap; the model steps on the edge the
   // request is taken. valid stays up afterwards so back-to-back keys
   // follow one another without a gap.
   task automatic send_key(input logic [KEY_W-1:0] key);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid    <= 1'b0;
         req_bus.key_code <= KEY_W'($urandom_range(0, KEY_UNUSED_TOP));
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.key_code <= key;
      do @(posedge clock); while (!req_bus.ready);
      awaited_status.push_back(apply_key(key));
      if ((key >= KEY_DIGIT_FIRST && key <= KEY_ZERO)
          || (key >= KEY_CONFIRM && key <= KEY_SAVE))
         presses_sent++;
   endtask

   // Stop offering and wait until every response is back: lock is idle.
   task automatic drain_lock();
      req_bus.valid <= 1'b0;
      while (awaited_status.size() != 0) @(posedge clock);
   endtask

   task automatic write_fail_limit(input logic [FAIL_W-1:0] limit);
      csr_write_en   <= 1'b1;
      csr_write_data <= limit;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      alarm_level = limit;
   endtask

   function automatic logic [KEY_W-1:0] digit_key(input int unsigned d);
      return (d == 0) ? KEY_ZERO : KEY_W'(d);
   endfunction

   function automatic int unsigned decimal_length(input int unsigned v);
      int unsigned n;
      n = 0;
      while (v > 0) begin
         v /= 10;
         n++;
      end
      return n;
   endfunction

   // type a value as exactly ndig digits, leading zeros included
   task automatic type_code(input int unsigned value, input int unsigned ndig);
      for (int i = ndig; i > 0; i--)
         send_key(digit_key((value / (10 ** (i - 1))) % 10));
   endtask

   task automatic type_random_digits(input int unsigned ndig);
      repeat (ndig) send_key(digit_key($urandom_range(0, 9)));
   endtask

   task automatic run_key_burst(input logic [KEY_W-1:0] top);
      repeat ($urandom_range(1, 8)) send_key(KEY_W'($urandom_range(0, top)));
   endtask

   // get back to a locked lock with an empty entry
   task automatic clear_lock_entry();
      if (session_open) begin
         if (change_count != CHANGE_ACTIVE) send_key(KEY_CHANGE);
         send_key(KEY_CHANGE);
      end
      repeat (typed_count) send_key(KEY_DELETE);
   endtask

   // correct code, then one of the ways a session can go
   task automatic run_unlock_session();
      int unsigned roll;
      int unsigned ndig;
      logic [KEY_W-1:0] junk;
      clear_lock_entry();
      if ($urandom_range(0, 3) == 0) begin
         send_key(digit_key($urandom_range(0, 9)));
         send_key(KEY_DELETE);
      end
      type_code(32'(saved_code),
                $urandom_range(decimal_length(32'(saved_code)), DIGITS));
      send_key(KEY_CONFIRM);
      if (!session_open) return;
      // keys that an open session ignores, change kept out
      if ($urandom_range(0, 2) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            junk = KEY_W'($urandom_range(0, KEY_UNUSED_TOP));
            send_key((junk == KEY_CHANGE) ? KEY_NONE : junk);
         end
      end
      roll = $urandom_range(0, 19);
      if (roll < 10) begin
         send_key(KEY_CHANGE);
         ndig = $urandom_range(0, DIGITS);
         if ($urandom_range(0, 9) == 0) ndig = DIGITS + 1;
         if ($urandom_range(0, 4) == 0) begin
            send_key(digit_key($urandom_range(0, 9)));
            send_key(KEY_DELETE);
         end
         type_random_digits(ndig);
         send_key(KEY_SAVE);
      end else if (roll < 14) begin
         send_key(KEY_CHANGE);
         type_random_digits($urandom_range(0, DIGITS));
         send_key(KEY_CHANGE);
      end else if (roll < 17) begin
         send_key(KEY_CHANGE);
         send_key(KEY_CHANGE);
      end else begin
         run_key_burst(KEY_UNUSED_TOP);
         clear_lock_entry();
      end
   endtask

   task automatic run_wrong_attempt();
      clear_lock_entry();
      type_random_digits($urandom_range(0, DIGITS + 1));
      send_key(KEY_CONFIRM);
   endtask

   // several misses in a row to reach the failure count ceiling
   task automatic run_miss_burst();
      clear_lock_entry();
      repeat ($urandom_range(5, 9)) begin
         type_random_digits($urandom_range(0, 2));
         send_key(KEY_CONFIRM);
      end
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   // unused codes and commands that mean nothing while locked
   task automatic test_idle_keys();
      send_key(KEY_NONE);
      send_key(KEY_UNUSED_A);
      send_key(KEY_UNUSED_TOP);
      send_key(KEY_SAVE);
      send_key(KEY_DELETE);
      send_key(KEY_CHANGE);
      send_key(KEY_UNUSED_B);
   endtask

   task automatic test_wrong_code();
      send_key(KEY_ZERO);
      send_key(KEY_CONFIRM);
   endtask

   // default code, a digit past full entry, delete and retype
   task automatic test_unlock_default();
      type_code(DEFAULT_CODE, DIGITS);
      send_key(digit_key(5));
      send_key(KEY_DELETE);
      send_key(digit_key(4));
      send_key(KEY_CONFIRM);
   endtask

   // locked-out digit, ignored confirm and save, then save an empty code
   task automatic test_change_code();
      send_key(digit_key(7));
      send_key(KEY_CONFIRM);
      send_key(KEY_SAVE);
      send_key(KEY_CHANGE);
      send_key(digit_key(9));
      send_key(KEY_DELETE);
      send_key(KEY_SAVE);
   endtask

   // empty entry now opens the lock; two change presses leave
   task automatic test_empty_code_and_leave();
      send_key(KEY_CONFIRM);
      send_key(KEY_CHANGE);
      send_key(KEY_CHANGE);
   endtask

   // receiver holds off while the sender keeps pushing, then sender pauses
   task automatic test_stall_and_drain();
      drain_lock();
      quiet         = 1'b1;
      stall_request = 1'b1;
      wait (stall_active);
      repeat (16) send_key(KEY_W'($urandom_range(0, KEY_SAVE)));
      drain_lock();
      quiet = 1'b0;
   endtask

   task automatic test_random_phase(input logic [FAIL_W-1:0] limit, input bit calm);
      int unsigned goal;
      int unsigned roll;
      drain_lock();
      write_fail_limit(limit);
      quiet = calm;
      goal  = presses_sent + PHASE_PRESSES;
      while (presses_sent < goal) begin
         roll = $urandom_range(0, 99);
         if (roll < 45)      run_unlock_session();
         else if (roll < 65) run_wrong_attempt();
         else if (roll < 75) run_miss_burst();
         else if (roll < 87) run_key_burst(KEY_SAVE);
         else                run_key_burst(KEY_UNUSED_TOP);
         if ($urandom_range(0, 49) == 0) drain_lock();
      end
      quiet = 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Response side: ready pattern, checker, watchdog
   // ---------------------------------------------------------------
   initial begin : drive_rsp_ready
      int unsigned gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (stall_request) begin
            stall_request = 1'b0;
            stall_active  = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (STALL_HOLD_CYCLES) @(posedge clock);
            stall_active  = 1'b0;
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   end

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : check_rsp
      lock_view_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_status.size() == 0) begin
            $display("%0t: response with no request outstanding", $time);
            errors++;
         end else begin
            want = awaited_status.pop_front();
            check_field("entry_value", 16'(want.value), 16'(rsp_bus.entry_value));
            check_field("entry_digits", 16'(want.digits), 16'(rsp_bus.entry_digits));
            check_field("unlocked", 16'(want.unlocked), 16'(rsp_bus.unlocked));
            check_field("change_mode", 16'(want.change_mode), 16'(rsp_bus.change_mode));
            check_field("wrong_code", 16'(want.wrong_code), 16'(rsp_bus.wrong_code));
            check_field("alarm", 16'(want.alarm), 16'(rsp_bus.alarm));
            check_field("session_end", 16'(want.session_end), 16'(rsp_bus.session_end));
         end
      end
   end

   // a hung handshake on either side ends the run
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------
   initial begin : run_tests
      req_bus.valid    <= 1'b0;
      req_bus.key_code <= KEY_NONE;
      csr_write_en     <= 1'b0;
      csr_write_data   <= '0;
      reset_lock_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_idle_keys();
      test_wrong_code();
      test_unlock_default();
      test_change_code();
      test_empty_code_and_leave();
      test_stall_and_drain();

      // alarm threshold sweep: top, zero (always raised), one, random, low, reset value
      test_random_phase(3'd7, 1'b0);
      test_random_phase(3'd0, 1'b0);
      test_random_phase(3'd1, 1'b1);
      test_random_phase(FAIL_W'($urandom_range(1, 7)), 1'b0);
      test_stall_and_drain();
      test_random_phase(3'd2, 1'b0);
      test_random_phase(FAIL_LIMIT_RESET, 1'b0);

      drain_lock();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
